/* rtl/core/ocvsoc_pkg.sv */
// Shared types and constants for the OCV state-of-charge estimator core.
// No dependencies; imported by ocvsoc_div and the top level of the core.
package ocvsoc_pkg;

    localparam int DIV_NW = 44;
    localparam int DIV_DW = 33;
    localparam int MUL_AW = 35;
    localparam int MUL_BW = 9;

    localparam logic [16:0] OCV_ROUND   = 17'd5;
    localparam logic [6:0]  PCT_DEFAULT = 7'd100;
    localparam int          OCV_SCALE   = 10;
    localparam int          PCT_SCALE   = 100;

    typedef enum logic [1:0] {
        FUNC_LOAD_TEMP = 2'd0,
        FUNC_LOAD_CAP  = 2'd1,
        FUNC_LOAD_OCV  = 2'd2,
        FUNC_ESTIMATE  = 2'd3
    } func_t;

    typedef enum logic {
        CFG_ROWS_USED    = 1'b0,
        CFG_COLUMNS_USED = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic                     start;
        logic signed [DIV_NW-1:0] dividend;
        logic signed [DIV_DW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [DIV_NW-1:0] quotient;
    } div_rsp_t;

endpackage

/* rtl/core/ocvsoc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ocvsoc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/ocvsoc_div.sv */
// Shared iterative signed divider, one quotient bit per cycle, truncating.
// Depends on ocvsoc_pkg.
module ocvsoc_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ocvsoc_pkg::div_req_t req,
    output ocvsoc_pkg::div_rsp_t rsp
);
    import ocvsoc_pkg::*;

    localparam int CNTW = $clog2(DIV_NW + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNTW-1:0]   cnt_reg;
    logic [DIV_NW-1:0] num_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic              neg_reg;

    logic [DIV_NW-1:0] num_abs;
    logic [DIV_DW-1:0] den_abs;
    logic [DIV_DW:0]   rem_sh;
    logic              fits;

    assign num_abs = req.dividend[DIV_NW-1] ? DIV_NW'(-req.dividend) : DIV_NW'(req.dividend);
    assign den_abs = req.divisor[DIV_DW-1] ? DIV_DW'(-req.divisor) : DIV_DW'(req.divisor);
    assign rem_sh  = {rem_reg, num_reg[DIV_NW-1]};
    assign fits    = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(DIV_NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= num_abs;
            den_reg <= den_abs;
            rem_reg <= '0;
            neg_reg <= req.dividend[DIV_NW-1] ^ req.divisor[DIV_DW-1];
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= DIV_DW'(rem_sh - {1'b0, den_reg});
                num_reg <= {num_reg[DIV_NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[DIV_DW-1:0];
                num_reg <= {num_reg[DIV_NW-2:0], 1'b0};
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? -$signed(num_reg) : $signed(num_reg);

endmodule

/* rtl/core/ocv_state_of_charge_estimator_core.sv */
// Top level of the OCV state-of-charge estimator: table storage and sequencer.
// Depends on ocvsoc_pkg, ocvsoc_ram and ocvsoc_div.
//
// A request is taken when start is high and busy is low. Load requests (func 0..2)
// complete without raising busy and give no result. An estimate (func 3) holds busy
// while one sequencer walks the tables and drives a shared iterative divider and a
// 35x9 multiplier; the OCV grid has a single read port, so each row takes one read
// on an exact column and two when two columns bracket the temperature.
// An estimate holds busy through three divisions, the column search, the row scan,
// up to three interpolations and the final steps; when full capacity is zero the
// last two divisions are skipped.
// The result appears for one cycle with done high and cannot be stalled; it must
// be captured then. Configuration writes are always ready.
module ocv_state_of_charge_estimator_core #(
    parameter int MAX_ROWS    = 32,
    parameter int MAX_COLUMNS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         func,
    input  logic [4:0]         row_index,
    input  logic [2:0]         column_index,
    input  logic signed [15:0] table_value,
    input  logic signed [7:0]  battery_temp,
    input  logic [15:0]        ocv_reading,
    input  logic signed [31:0] charge_count,
    input  logic [30:0]        full_capacity,
    output logic               done,
    output logic signed [15:0] state_of_charge,
    output logic [6:0]         table_percent,
    output logic               status,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [5:0]         cfg_data
);
    import ocvsoc_pkg::*;

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int AW = $clog2(MAX_ROWS * MAX_COLUMNS);

    typedef enum logic [4:0] {
        S_IDLE, S_XW, S_COL,
        S_ERL, S_ERLD, S_ER0, S_ER0D, S_ERI, S_ERID,
        S_TR0, S_TR0D, S_TRL, S_TRLD, S_TB, S_TBD, S_TC, S_TCD, S_TE, S_TED,
        S_TCALC, S_LCHK, S_LDIV, S_LDW, S_LRET,
        S_FIN, S_FD1, S_FW1, S_FM2, S_FD2, S_FW2
    } state_t;

    typedef enum logic [1:0] {
        RET_PH,
        RET_PL,
        RET_PCT
    } ret_t;

    state_t state_reg;

    logic [5:0]        rows_used_reg;
    logic [3:0]        cols_used_reg;
    logic [CW:0]       j_reg;
    logic [RW-1:0]     i_reg;
    logic [CW-1:0]     chi_reg;
    logic [CW-1:0]     clo_reg;
    logic signed [7:0] t_reg;
    logic signed [7:0] tprev_reg;
    logic signed [7:0] thi_reg;
    logic [12:0]       x_reg;
    logic signed [31:0] cc_reg;
    logic [30:0]       fcc_reg;
    logic              le_last_reg;
    logic [6:0]        cap_last_reg;
    logic signed [17:0] ph_reg;
    logic signed [17:0] pl_reg;
    logic signed [17:0] nh_reg;
    logic [6:0]        pcap_reg;
    logic [6:0]        ncap_reg;
    logic              hit_h_reg;
    logic              hit_l_reg;
    logic [6:0]        hy0_reg, hy1_reg, ly0_reg, ly1_reg;
    logic signed [17:0] hx0_reg, hx1_reg, lx0_reg, lx1_reg;
    logic [6:0]        ay0_reg, ay1_reg;
    logic signed [17:0] ax0_reg, ax1_reg, axx_reg;
    ret_t              lret_reg;
    logic [6:0]        lres_reg;
    logic [6:0]        phv_reg;
    logic [6:0]        pct_reg;
    logic signed [33:0] d_reg;
    logic signed [DIV_NW-1:0] prod_reg;
    logic signed [15:0] soc_reg;
    logic              status_reg;
    logic              done_reg;

    logic signed [7:0] temp_mem [MAX_COLUMNS];

    logic              accept;
    logic              row_ok;
    logic              col_ok;
    logic [6:0]        ru7;
    logic [6:0]        rows7;
    logic [RW-1:0]     rows_m1;
    logic [4:0]        cu5;
    logic [4:0]        cols5;
    logic [CW:0]       cols;
    logic signed [7:0] tj;

    logic [RW-1:0]     rd_row;
    logic [CW-1:0]     rd_col;
    logic [AW-1:0]     ocv_raddr;
    logic [AW-1:0]     ocv_waddr;
    logic [15:0]       ocv_rd;
    logic [6:0]        cap_rd;
    logic signed [17:0] cell_s;
    logic signed [17:0] x_s;

    logic signed [18:0] ldx;
    logic signed [18:0] lden;
    logic signed [8:0]  ldy;
    logic signed [MUL_AW-1:0] mul_a;
    logic signed [MUL_BW-1:0] mul_b;
    logic signed [DIV_NW-1:0] prod_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic wh;
    logic wl;
    logic newh;
    logic newl;

    function automatic logic spans(input logic signed [17:0] a, input logic signed [17:0] b,
                                   input logic signed [17:0] v);
        spans = (a >= b && a >= v && v >= b) || (a <= b && a <= v && v <= b);
    endfunction

    assign accept    = start && !busy;
    assign busy      = state_reg != S_IDLE;
    assign cfg_ready = 1'b1;
    assign row_ok    = 32'(row_index) < MAX_ROWS;
    assign col_ok    = 32'(column_index) < MAX_COLUMNS;

    assign ru7     = {1'b0, rows_used_reg};
    assign rows7   = (ru7 < 7'd2) ? 7'd2 : (ru7 > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : ru7;
    assign rows_m1 = RW'(rows7 - 7'd1);
    assign cu5     = {1'b0, cols_used_reg};
    assign cols5   = (cu5 < 5'd1) ? 5'd1 : (cu5 > 5'(MAX_COLUMNS)) ? 5'(MAX_COLUMNS) : cu5;
    assign cols    = (CW+1)'(cols5);
    assign tj      = temp_mem[j_reg[CW-1:0]];

    always_comb
    begin
        rd_row = '0;
        rd_col = chi_reg;
        case (state_reg)
            S_ERL:   rd_row = rows_m1;
            S_ER0:   rd_row = '0;
            S_ERI:   rd_row = i_reg;
            S_TR0:   rd_row = '0;
            S_TRL:
            begin
                rd_row = rows_m1;
                rd_col = clo_reg;
            end
            S_TB:    rd_col = clo_reg;
            S_TC:    rd_row = RW'(i_reg + 1'b1);
            S_TE:
            begin
                rd_row = RW'(i_reg + 1'b1);
                rd_col = clo_reg;
            end
            default: rd_row = '0;
        endcase
    end

    assign ocv_raddr = AW'(rd_row) * AW'(MAX_COLUMNS) + AW'(rd_col);
    assign ocv_waddr = AW'(row_index) * AW'(MAX_COLUMNS) + AW'(column_index);
    assign cell_s    = {{2{ocv_rd[15]}}, ocv_rd};
    assign x_s       = {5'b0, x_reg};

    ocvsoc_ram #(
        .WIDTH(16),
        .DEPTH(MAX_ROWS * MAX_COLUMNS)
    ) u_ocv_ram (
        .clk  (clk),
        .we   (accept && func == FUNC_LOAD_OCV && row_ok && col_ok),
        .waddr(ocv_waddr),
        .wdata(table_value),
        .raddr(ocv_raddr),
        .rdata(ocv_rd)
    );

    ocvsoc_ram #(
        .WIDTH(7),
        .DEPTH(MAX_ROWS)
    ) u_cap_ram (
        .clk  (clk),
        .we   (accept && func == FUNC_LOAD_CAP && row_ok),
        .waddr(RW'(row_index)),
        .wdata(table_value[6:0]),
        .raddr(rd_row),
        .rdata(cap_rd)
    );

    ocvsoc_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .rsp  (div_rsp)
    );

    assign ldx  = {axx_reg[17], axx_reg} - {ax0_reg[17], ax0_reg};
    assign lden = {ax1_reg[17], ax1_reg} - {ax0_reg[17], ax0_reg};
    assign ldy  = $signed({2'b0, ay1_reg}) - $signed({2'b0, ay0_reg});

    always_comb
    begin
        case (state_reg)
            S_LCHK:
            begin
                mul_a = MUL_AW'(ldx);
                mul_b = ldy;
            end
            S_FIN:
            begin
                mul_a = $signed({4'b0, fcc_reg});
                mul_b = $signed({2'b0, pct_reg});
            end
            S_FM2:
            begin
                mul_a = MUL_AW'(d_reg);
                mul_b = MUL_BW'(PCT_SCALE);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = prod_reg;
        div_req.divisor  = DIV_DW'(PCT_SCALE);
        case (state_reg)
            S_IDLE:
            begin
                div_req.start    = accept && func == FUNC_ESTIMATE;
                div_req.dividend = $signed({27'b0, {1'b0, ocv_reading} + OCV_ROUND});
                div_req.divisor  = DIV_DW'(OCV_SCALE);
            end
            S_LDIV:
            begin
                div_req.start   = 1'b1;
                div_req.divisor = DIV_DW'(lden);
            end
            S_FD1:   div_req.start = 1'b1;
            S_FD2:
            begin
                div_req.start   = 1'b1;
                div_req.divisor = $signed({2'b0, fcc_reg});
            end
            default: div_req.start = 1'b0;
        endcase
    end

    assign wh   = spans(ph_reg, nh_reg, x_s);
    assign wl   = spans(pl_reg, cell_s, x_s);
    assign newh = hit_h_reg || wh;
    assign newl = hit_l_reg || wl;

    always_ff @(posedge clk)
    begin
        if (accept && func == FUNC_LOAD_TEMP && col_ok)
        begin
            temp_mem[CW'(column_index)] <= table_value[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rows_used_reg <= 6'd32;
            cols_used_reg <= 4'd8;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            prod_reg <= prod_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_ROWS_USED:    rows_used_reg <= cfg_data;
                    CFG_COLUMNS_USED: cols_used_reg <= cfg_data[3:0];
                    default:          rows_used_reg <= rows_used_reg;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && func == FUNC_ESTIMATE)
                    begin
                        t_reg     <= battery_temp;
                        cc_reg    <= charge_count;
                        fcc_reg   <= full_capacity;
                        state_reg <= S_XW;
                    end
                end
                S_XW:
                begin
                    if (div_rsp.done)
                    begin
                        x_reg     <= div_rsp.quotient[12:0];
                        j_reg     <= '0;
                        state_reg <= S_COL;
                    end
                end
                S_COL:
                begin
                    if (j_reg < cols && t_reg > tj)
                    begin
                        tprev_reg <= tj;
                        j_reg     <= j_reg + 1'b1;
                    end
                    else if (j_reg == cols || j_reg == '0 || t_reg == tj)
                    begin
                        chi_reg   <= (j_reg == cols) ? CW'(cols - 1'b1) : CW'(j_reg);
                        state_reg <= S_ERL;
                    end
                    else
                    begin
                        chi_reg   <= CW'(j_reg);
                        clo_reg   <= CW'(j_reg - 1'b1);
                        thi_reg   <= tj;
                        state_reg <= S_TR0;
                    end
                end
                S_ERL:   state_reg <= S_ERLD;
                S_ERLD:
                begin
                    le_last_reg  <= x_s <= cell_s;
                    cap_last_reg <= cap_rd;
                    state_reg    <= S_ER0;
                end
                S_ER0:   state_reg <= S_ER0D;
                S_ER0D:
                begin
                    if (x_s >= cell_s)
                    begin
                        pct_reg   <= cap_rd;
                        state_reg <= S_FIN;
                    end
                    else if (le_last_reg)
                    begin
                        pct_reg   <= cap_last_reg;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        ph_reg    <= cell_s;
                        pcap_reg  <= cap_rd;
                        i_reg     <= RW'(1);
                        state_reg <= S_ERI;
                    end
                end
                S_ERI:   state_reg <= S_ERID;
                S_ERID:
                begin
                    if (x_s >= cell_s)
                    begin
                        if (x_s == cell_s)
                        begin
                            pct_reg   <= cap_rd;
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            ay0_reg   <= cap_rd;
                            ax0_reg   <= cell_s;
                            ay1_reg   <= pcap_reg;
                            ax1_reg   <= ph_reg;
                            axx_reg   <= x_s;
                            lret_reg  <= RET_PCT;
                            state_reg <= S_LCHK;
                        end
                    end
                    else if (i_reg == rows_m1)
                    begin
                        pct_reg   <= cap_rd;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        ph_reg    <= cell_s;
                        pcap_reg  <= cap_rd;
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_ERI;
                    end
                end
                S_TR0:   state_reg <= S_TR0D;
                S_TR0D:
                begin
                    if (x_s >= cell_s)
                    begin
                        pct_reg   <= cap_rd;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        ph_reg    <= cell_s;
                        pcap_reg  <= cap_rd;
                        state_reg <= S_TRL;
                    end
                end
                S_TRL:   state_reg <= S_TRLD;
                S_TRLD:
                begin
                    if (x_s <= cell_s)
                    begin
                        pct_reg   <= cap_rd;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_TB;
                    end
                end
                S_TB:    state_reg <= S_TBD;
                S_TBD:
                begin
                    pl_reg    <= cell_s;
                    i_reg     <= '0;
                    hit_h_reg <= 1'b0;
                    hit_l_reg <= 1'b0;
                    state_reg <= S_TC;
                end
                S_TC:    state_reg <= S_TCD;
                S_TCD:
                begin
                    nh_reg    <= cell_s;
                    ncap_reg  <= cap_rd;
                    state_reg <= S_TE;
                end
                S_TE:    state_reg <= S_TED;
                S_TED:
                begin
                    if (!hit_h_reg && wh)
                    begin
                        hy0_reg <= pcap_reg;
                        hx0_reg <= ph_reg;
                        hy1_reg <= ncap_reg;
                        hx1_reg <= nh_reg;
                    end
                    if (!hit_l_reg && wl)
                    begin
                        ly0_reg <= pcap_reg;
                        lx0_reg <= pl_reg;
                        ly1_reg <= ncap_reg;
                        lx1_reg <= cell_s;
                    end
                    hit_h_reg <= newh;
                    hit_l_reg <= newl;
                    if ((newh && newl) || RW'(i_reg + 1'b1) == rows_m1)
                    begin
                        state_reg <= S_TCALC;
                    end
                    else
                    begin
                        ph_reg    <= nh_reg;
                        pl_reg    <= cell_s;
                        pcap_reg  <= ncap_reg;
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_TC;
                    end
                end
                S_TCALC:
                begin
                    axx_reg <= x_s;
                    if (hit_h_reg)
                    begin
                        ay0_reg   <= hy0_reg;
                        ax0_reg   <= hx0_reg;
                        ay1_reg   <= hy1_reg;
                        ax1_reg   <= hx1_reg;
                        lret_reg  <= RET_PH;
                        state_reg <= S_LCHK;
                    end
                    else if (hit_l_reg)
                    begin
                        ay0_reg   <= ly0_reg;
                        ax0_reg   <= lx0_reg;
                        ay1_reg   <= ly1_reg;
                        ax1_reg   <= lx1_reg;
                        lret_reg  <= RET_PL;
                        state_reg <= S_LCHK;
                    end
                    else
                    begin
                        pct_reg   <= PCT_DEFAULT;
                        state_reg <= S_FIN;
                    end
                end
                S_LCHK:
                begin
                    if (ay0_reg == ay1_reg || axx_reg == ax0_reg)
                    begin
                        lres_reg  <= ay0_reg;
                        state_reg <= S_LRET;
                    end
                    else if (ax1_reg == ax0_reg || axx_reg == ax1_reg)
                    begin
                        lres_reg  <= ay1_reg;
                        state_reg <= S_LRET;
                    end
                    else
                    begin
                        state_reg <= S_LDIV;
                    end
                end
                S_LDIV:  state_reg <= S_LDW;
                S_LDW:
                begin
                    if (div_rsp.done)
                    begin
                        lres_reg  <= ay0_reg + div_rsp.quotient[6:0];
                        state_reg <= S_LRET;
                    end
                end
                S_LRET:
                begin
                    case (lret_reg)
                        RET_PH:
                        begin
                            phv_reg <= lres_reg;
                            if (hit_l_reg)
                            begin
                                ay0_reg   <= ly0_reg;
                                ax0_reg   <= lx0_reg;
                                ay1_reg   <= ly1_reg;
                                ax1_reg   <= lx1_reg;
                                lret_reg  <= RET_PL;
                                state_reg <= S_LCHK;
                            end
                            else
                            begin
                                pct_reg   <= lres_reg;
                                state_reg <= S_FIN;
                            end
                        end
                        RET_PL:
                        begin
                            if (hit_h_reg)
                            begin
                                ay0_reg   <= lres_reg;
                                ax0_reg   <= 18'(tprev_reg);
                                ay1_reg   <= phv_reg;
                                ax1_reg   <= 18'(thi_reg);
                                axx_reg   <= 18'(t_reg);
                                lret_reg  <= RET_PCT;
                                state_reg <= S_LCHK;
                            end
                            else
                            begin
                                pct_reg   <= lres_reg;
                                state_reg <= S_FIN;
                            end
                        end
                        default:
                        begin
                            pct_reg   <= lres_reg;
                            state_reg <= S_FIN;
                        end
                    endcase
                end
                S_FIN:
                begin
                    if (fcc_reg == '0)
                    begin
                        soc_reg    <= '0;
                        status_reg <= 1'b1;
                        done_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_FD1;
                    end
                end
                S_FD1:   state_reg <= S_FW1;
                S_FW1:
                begin
                    if (div_rsp.done)
                    begin
                        d_reg     <= 34'(div_rsp.quotient) - 34'(cc_reg);
                        state_reg <= S_FM2;
                    end
                end
                S_FM2:   state_reg <= S_FD2;
                S_FD2:   state_reg <= S_FW2;
                S_FW2:
                begin
                    if (div_rsp.done)
                    begin
                        if (div_rsp.quotient > DIV_NW'(32767))
                        begin
                            soc_reg <= 16'sh7FFF;
                        end
                        else if (div_rsp.quotient < -DIV_NW'(32768))
                        begin
                            soc_reg <= -16'sh8000;
                        end
                        else
                        begin
                            soc_reg <= div_rsp.quotient[15:0];
                        end
                        status_reg <= 1'b0;
                        done_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign done            = done_reg;
    assign state_of_charge = soc_reg;
    assign table_percent   = pct_reg;
    assign status          = status_reg;

endmodule
